// ----- rtl/aabr_pkg.sv -----
// ----------------------------------------------------------------------------
// aabr_pkg
// Shared types and codes for the data-abort base-register restore pipeline.
// ----------------------------------------------------------------------------
package aabr_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned RegW   = 4;
  localparam int unsigned ClsW   = 4;
  localparam int unsigned CountW = 5;

  // instruction class, bits 27:24
  localparam logic [ClsW-1:0] CLS_HALF_POST = 4'd0;
  localparam logic [ClsW-1:0] CLS_HALF_PRE  = 4'd1;
  localparam logic [ClsW-1:0] CLS_IMM_POST  = 4'd4;
  localparam logic [ClsW-1:0] CLS_IMM_PRE   = 4'd5;
  localparam logic [ClsW-1:0] CLS_REG_POST  = 4'd6;
  localparam logic [ClsW-1:0] CLS_REG_PRE   = 4'd7;
  localparam logic [ClsW-1:0] CLS_MULTI_A   = 4'd8;
  localparam logic [ClsW-1:0] CLS_MULTI_B   = 4'd9;
  localparam logic [ClsW-1:0] CLS_COPROC_POST = 4'd12;
  localparam logic [ClsW-1:0] CLS_COPROC_PRE  = 4'd13;
  // not load/store
  localparam logic [ClsW-1:0] CLS_DP_IMM    = 4'd2;
  localparam logic [ClsW-1:0] CLS_SWI       = 4'd15;

  // shift type, bits 6:5
  localparam logic [1:0] SHIFT_LSL = 2'd0;
  localparam logic [1:0] SHIFT_LSR = 2'd1;
  localparam logic [1:0] SHIFT_ASR = 2'd2;
  localparam logic [1:0] SHIFT_ROR = 2'd3;

  typedef struct packed {
    logic [WordW-1:0]  base;
    logic [RegW-1:0]   rn;
    logic [ClsW-1:0]   cls;
    logic              wb;
    logic              up;
    logic              imm_sel;
    logic [7:0]        imm8;
    logic [11:0]       imm12;
    logic [7:0]        cp8;
    logic [WordW-1:0]  rm;
    logic [WordW-1:0]  shifted;
    logic [CountW-1:0] count;
  } dec_t;

  typedef struct packed {
    logic [WordW-1:0] base;
    logic [RegW-1:0]  rn;
    logic             wb;
    logic [WordW-1:0] addend;
    logic             cin;
  } off_t;

endpackage

// ----- rtl/aabr_decode.sv -----
// ----------------------------------------------------------------------------
// aabr_decode
// Stage 1: field extraction, write-back decode, Rm shifter, register count.
// ----------------------------------------------------------------------------
module aabr_decode (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [aabr_pkg::WordW-1:0] instruction,
  input  logic [aabr_pkg::WordW-1:0] base_value,
  input  logic [aabr_pkg::WordW-1:0] index_value,
  input  logic                      carry_flag,
  output logic                      out_valid,
  input  logic                      out_stall,
  output aabr_pkg::dec_t            out_data
);

  aabr_pkg::dec_t               dec_next;
  logic                         valid;
  logic [4:0]                   amount;
  logic [1:0]                   stype;
  logic [aabr_pkg::WordW-1:0]   fill;
  logic [2*aabr_pkg::WordW-1:0] rot;
  logic [aabr_pkg::WordW-1:0]   shifted_next;
  logic [2:0]                   nib_cnt [4];
  logic                         post;

  assign amount = instruction[11:7];
  assign stype  = instruction[6:5];
  assign fill   = {aabr_pkg::WordW{index_value[31]}};
  assign rot    = {index_value, index_value} >> amount;

  always_comb begin
    unique case (stype)
      aabr_pkg::SHIFT_LSL: shifted_next = index_value << amount;
      aabr_pkg::SHIFT_LSR: shifted_next = (amount == 5'd0) ? '0 : (index_value >> amount);
      aabr_pkg::SHIFT_ASR: shifted_next = (amount == 5'd0) ? fill :
                                          32'($signed(index_value) >>> amount);
      aabr_pkg::SHIFT_ROR: shifted_next = (amount == 5'd0) ?
                                          {carry_flag, index_value[31:1]} : rot[31:0];
      default:             shifted_next = '0;
    endcase
  end

  always_comb begin
    for (int n = 0; n < 4; n++) begin
      nib_cnt[n] = 3'd0;
      for (int b = 0; b < 4; b++) begin
        nib_cnt[n] = nib_cnt[n] + 3'(instruction[4*n+b]);
      end
    end
  end

  always_comb begin
    unique case (instruction[27:24]) inside
      aabr_pkg::CLS_HALF_POST, aabr_pkg::CLS_IMM_POST,
      aabr_pkg::CLS_REG_POST,  aabr_pkg::CLS_COPROC_POST: post = 1'b1;
      default:                                            post = 1'b0;
    endcase
  end

  always_comb begin
    dec_next.base    = base_value;
    dec_next.rn      = instruction[19:16];
    dec_next.cls     = instruction[27:24];
    dec_next.wb      = instruction[21] | post;
    dec_next.up      = instruction[23];
    dec_next.imm_sel = instruction[22];
    dec_next.imm8    = {instruction[11:8], instruction[3:0]};
    dec_next.imm12   = instruction[11:0];
    dec_next.cp8     = instruction[7:0];
    dec_next.rm      = index_value;
    dec_next.shifted = shifted_next;
    dec_next.count   = (5'(nib_cnt[0]) + 5'(nib_cnt[1])) +
                       (5'(nib_cnt[2]) + 5'(nib_cnt[3]));
  end

  assign in_stall  = valid & out_stall;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!in_stall) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      out_data <= dec_next;
    end
  end

endmodule

// ----- rtl/aabr_offset.sv -----
// ----------------------------------------------------------------------------
// aabr_offset
// Stage 2: offset select by class and conditional negate for the undo.
// ----------------------------------------------------------------------------
module aabr_offset (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  aabr_pkg::dec_t in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output aabr_pkg::off_t out_data
);

  aabr_pkg::off_t             off_next;
  logic [aabr_pkg::WordW-1:0] offset;
  logic                       valid;

  always_comb begin
    case (in_data.cls) inside
      aabr_pkg::CLS_HALF_POST, aabr_pkg::CLS_HALF_PRE:
        offset = in_data.imm_sel ? {24'd0, in_data.imm8} : in_data.rm;
      aabr_pkg::CLS_IMM_POST, aabr_pkg::CLS_IMM_PRE:
        offset = {20'd0, in_data.imm12};
      aabr_pkg::CLS_REG_POST, aabr_pkg::CLS_REG_PRE:
        offset = in_data.shifted;
      aabr_pkg::CLS_MULTI_A, aabr_pkg::CLS_MULTI_B:
        offset = {25'd0, in_data.count, 2'b00};
      aabr_pkg::CLS_COPROC_POST, aabr_pkg::CLS_COPROC_PRE:
        offset = {22'd0, in_data.cp8, 2'b00};
      default:
        offset = '0;
    endcase
  end

  // U set: base - offset = base + ~offset + 1
  always_comb begin
    off_next.base   = in_data.base;
    off_next.rn     = in_data.rn;
    off_next.wb     = in_data.wb;
    off_next.addend = in_data.wb ? (in_data.up ? ~offset : offset) : '0;
    off_next.cin    = in_data.wb & in_data.up;
  end

  assign in_stall  = valid & out_stall;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!in_stall) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      out_data <= off_next;
    end
  end

endmodule

// ----- rtl/aabr_restore.sv -----
// ----------------------------------------------------------------------------
// aabr_restore
// Stage 3: base add and output register.
// ----------------------------------------------------------------------------
module aabr_restore (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  aabr_pkg::off_t             in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [aabr_pkg::WordW-1:0] restored_base,
  output logic                       base_write_enable,
  output logic [aabr_pkg::RegW-1:0]  base_index
);

  logic [aabr_pkg::WordW-1:0] sum_next;
  logic                       valid;

  assign sum_next  = in_data.base + in_data.addend + {{(aabr_pkg::WordW-1){1'b0}}, in_data.cin};
  assign in_stall  = valid & out_stall;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!in_stall) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      restored_base     <= sum_next;
      base_write_enable <= in_data.wb;
      base_index        <= in_data.rn;
    end
  end

endmodule

// ----- rtl/arm_abort_base_restore.sv -----
// ----------------------------------------------------------------------------
// arm_abort_base_restore
// Each instruction passes through three registered stages in order before
// result_valid rises for it.
// Throughput: one instruction per cycle while result_stall is low; stages
// are decode/shift, offset select, base add.
// Reset: rst (sync, active high) empties all three stages; data regs unreset.
// ----------------------------------------------------------------------------
module arm_abort_base_restore (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       instr_valid,
  output logic                       instr_stall,
  input  logic [aabr_pkg::WordW-1:0] instruction,
  input  logic [aabr_pkg::WordW-1:0] base_value,
  input  logic [aabr_pkg::WordW-1:0] index_value,
  input  logic                       carry_flag,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic [aabr_pkg::WordW-1:0] restored_base,
  output logic                       base_write_enable,
  output logic [aabr_pkg::RegW-1:0]  base_index
);

  aabr_pkg::dec_t dec_data;
  aabr_pkg::off_t off_data;
  logic           dec_valid;
  logic           dec_stall;
  logic           off_valid;
  logic           off_stall;

  aabr_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (instr_valid),
    .in_stall    (instr_stall),
    .instruction (instruction),
    .base_value  (base_value),
    .index_value (index_value),
    .carry_flag  (carry_flag),
    .out_valid   (dec_valid),
    .out_stall   (dec_stall),
    .out_data    (dec_data)
  );

  aabr_offset u_offset (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dec_valid),
    .in_stall  (dec_stall),
    .in_data   (dec_data),
    .out_valid (off_valid),
    .out_stall (off_stall),
    .out_data  (off_data)
  );

  aabr_restore u_restore (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (off_valid),
    .in_stall          (off_stall),
    .in_data           (off_data),
    .out_valid         (result_valid),
    .out_stall         (result_stall),
    .restored_base     (restored_base),
    .base_write_enable (base_write_enable),
    .base_index        (base_index)
  );

endmodule

// ----- rtl/aabr_checker.sv -----
// ----------------------------------------------------------------------------
// aabr_checker
// Port-level checks for arm_abort_base_restore.
// ----------------------------------------------------------------------------
module aabr_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       instr_valid,
  input logic                       instr_stall,
  input logic [aabr_pkg::WordW-1:0] instruction,
  input logic [aabr_pkg::WordW-1:0] base_value,
  input logic [aabr_pkg::WordW-1:0] index_value,
  input logic                       carry_flag,
  input logic                       result_valid,
  input logic                       result_stall,
  input logic [aabr_pkg::WordW-1:0] restored_base,
  input logic                       base_write_enable,
  input logic [aabr_pkg::RegW-1:0]  base_index
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result_valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(restored_base)
      && $stable(base_write_enable) && $stable(base_index))
    else $error("stalled result changed");

  a_post_wb: assert property (@(posedge clk) disable iff (rst)
    (instr_valid && !instr_stall && instruction[27:24] == aabr_pkg::CLS_HALF_POST)
      ##1 !result_stall ##1 !result_stall
      |=> result_valid && base_write_enable && base_index == $past(instruction[19:16], 3))
    else $error("post-indexed transfer lost writeback");

  a_pre_nowb: assert property (@(posedge clk) disable iff (rst)
    (instr_valid && !instr_stall && instruction[27:24] == aabr_pkg::CLS_IMM_PRE
      && !instruction[21])
      ##1 !result_stall ##1 !result_stall
      |=> result_valid && !base_write_enable && restored_base == $past(base_value, 3))
    else $error("pre-indexed transfer without W altered base");

endmodule

bind arm_abort_base_restore aabr_checker u_aabr_checker (.*);

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks arm_abort_base_restore against an in-bench predictor of the base
// undo: directed instructions for every class, shift type and writeback rule,
// then random instructions under random, bursty and back-pressured traffic.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 120;
  localparam int unsigned IdlePct    = 24;

  typedef struct packed {
    logic [aabr_pkg::WordW-1:0] base;
    logic                       wen;
    logic [aabr_pkg::RegW-1:0]  rn;
  } restore_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       instr_valid;
  logic                       instr_stall;
  logic [aabr_pkg::WordW-1:0] instruction;
  logic [aabr_pkg::WordW-1:0] base_value;
  logic [aabr_pkg::WordW-1:0] index_value;
  logic                       carry_flag;
  logic                       result_valid;
  logic                       result_stall = 1'b0;
  logic [aabr_pkg::WordW-1:0] restored_base;
  logic                       base_write_enable;
  logic [aabr_pkg::RegW-1:0]  base_index;

  restore_t    pending_restores[$];
  int unsigned errors = 0;
  int unsigned sent_count = 0;
  int unsigned checked_count = 0;
  int unsigned cycles = 0;
  int unsigned hold_token = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  logic        sender_idles = 1'b1;
  logic        receiver_idles = 1'b1;

  arm_abort_base_restore i_dut (
    .clk               (clk),
    .rst               (rst),
    .instr_valid       (instr_valid),
    .instr_stall       (instr_stall),
    .instruction       (instruction),
    .base_value        (base_value),
    .index_value       (index_value),
    .carry_flag        (carry_flag),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .restored_base     (restored_base),
    .base_write_enable (base_write_enable),
    .base_index        (base_index)
  );

  always #5 clk = ~clk;

  function automatic logic [aabr_pkg::WordW-1:0] shift_index(
      input logic [aabr_pkg::WordW-1:0] instr,
      input logic [aabr_pkg::WordW-1:0] rm,
      input logic carry);
    logic [4:0]                 amount;
    logic [1:0]                 kind;
    logic [aabr_pkg::WordW-1:0] fill;
    amount = instr[11:7];
    kind   = instr[6:5];
    fill   = {aabr_pkg::WordW{rm[31]}};
    case (kind)
      aabr_pkg::SHIFT_LSL: return rm << amount;
      aabr_pkg::SHIFT_LSR: return (amount == 0) ? '0 : rm >> amount;
      aabr_pkg::SHIFT_ASR: return (amount == 0) ? fill
                                                : (rm >> amount) | (fill << (32 - amount));
      default:             return (amount == 0) ? {carry, rm[31:1]}
                                                : (rm >> amount) | (rm << (32 - amount));
    endcase
  endfunction

  function automatic restore_t predict_restore(input logic [aabr_pkg::WordW-1:0] instr,
                                               input logic [aabr_pkg::WordW-1:0] base,
                                               input logic [aabr_pkg::WordW-1:0] rm,
                                               input logic carry);
    logic [aabr_pkg::ClsW-1:0]  cls;
    logic                       wb;
    logic [aabr_pkg::WordW-1:0] offset;
    restore_t                   r;
    cls    = instr[27:24];
    wb     = instr[21];
    offset = '0;
    case (cls) inside
      aabr_pkg::CLS_HALF_POST, aabr_pkg::CLS_HALF_PRE: begin
        if (cls == aabr_pkg::CLS_HALF_POST) wb = 1'b1;
        offset = instr[22] ? {24'd0, instr[11:8], instr[3:0]} : rm;
      end
      aabr_pkg::CLS_IMM_POST, aabr_pkg::CLS_IMM_PRE: begin
        if (cls == aabr_pkg::CLS_IMM_POST) wb = 1'b1;
        offset = {20'd0, instr[11:0]};
      end
      aabr_pkg::CLS_REG_POST, aabr_pkg::CLS_REG_PRE: begin
        if (cls == aabr_pkg::CLS_REG_POST) wb = 1'b1;
        offset = shift_index(instr, rm, carry);
      end
      aabr_pkg::CLS_MULTI_A, aabr_pkg::CLS_MULTI_B: begin
        for (int i = 0; i < 16; i++) offset += {29'd0, instr[i], 2'b00};
      end
      aabr_pkg::CLS_COPROC_POST, aabr_pkg::CLS_COPROC_PRE: begin
        if (cls == aabr_pkg::CLS_COPROC_POST) wb = 1'b1;
        offset = {22'd0, instr[7:0], 2'b00};
      end
      default: offset = '0;
    endcase
    r.base = !wb ? base : instr[23] ? base - offset : base + offset;
    r.wen  = wb;
    r.rn   = instr[19:16];
    return r;
  endfunction

  // transfer monitor, scoreboard and run limit
  always @(posedge clk) begin
    restore_t exp_r;
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("Mismatches found");
      $finish;
    end else if (!rst) begin
      if (instr_valid && !instr_stall) begin
        pending_restores.push_back(predict_restore(instruction, base_value, index_value,
                                                   carry_flag));
        sent_count++;
      end
      if (result_valid && !result_stall) begin
        if (pending_restores.size() == 0) begin
          errors++;
          $display("%0t: unexpected result base %h wen %b rn %0d", $time,
                   restored_base, base_write_enable, base_index);
        end else begin
          exp_r = pending_restores.pop_front();
          checked_count++;
          if (restored_base !== exp_r.base || base_write_enable !== exp_r.wen ||
              base_index !== exp_r.rn) begin
            errors++;
            $display({"%0t: mismatch expected base %h wen %b rn %0d,",
                      " actual base %h wen %b rn %0d"},
                     $time, exp_r.base, exp_r.wen, exp_r.rn,
                     restored_base, base_write_enable, base_index);
          end
        end
      end
    end
  end

  // result side: random stall, long hold-off on request
  always @(negedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen    <= hold_token;
      hold_left    <= HoldCycles;
      result_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= receiver_idles && ($urandom_range(0, 99) < IdlePct);
    end
  end

  task automatic send_instr(input logic [aabr_pkg::WordW-1:0] instr,
                            input logic [aabr_pkg::WordW-1:0] base,
                            input logic [aabr_pkg::WordW-1:0] rm, input logic carry);
    @(negedge clk);
    while (sender_idles && ($urandom_range(0, 99) < IdlePct)) begin
      instr_valid <= 1'b0;
      @(negedge clk);
    end
    instr_valid <= 1'b1;
    instruction <= instr;
    base_value  <= base;
    index_value <= rm;
    carry_flag  <= carry;
    do @(posedge clk); while (instr_stall);
  endtask

  task automatic drain_results();
    @(negedge clk);
    instr_valid <= 1'b0;
    while (pending_restores.size() != 0) @(posedge clk);
  endtask

  function automatic logic [aabr_pkg::WordW-1:0] encode(input logic [aabr_pkg::ClsW-1:0] cls,
                                                        input logic up,
                                                        input logic b22, input logic wb,
                                                        input logic [aabr_pkg::RegW-1:0] rn,
                                                        input logic [15:0] low);
    return {4'hE, cls, up, b22, wb, 1'b1, rn, low};
  endfunction

  function automatic logic [aabr_pkg::WordW-1:0] random_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [aabr_pkg::WordW-1:0] random_instr();
    logic [aabr_pkg::WordW-1:0] w;
    w = $urandom;
    if ($urandom_range(0, 9) != 0) begin
      case ($urandom_range(0, 9))
        0: w[27:24] = aabr_pkg::CLS_HALF_POST;
        1: w[27:24] = aabr_pkg::CLS_HALF_PRE;
        2: w[27:24] = aabr_pkg::CLS_IMM_POST;
        3: w[27:24] = aabr_pkg::CLS_IMM_PRE;
        4: w[27:24] = aabr_pkg::CLS_REG_POST;
        5: w[27:24] = aabr_pkg::CLS_REG_PRE;
        6: w[27:24] = aabr_pkg::CLS_MULTI_A;
        7: w[27:24] = aabr_pkg::CLS_MULTI_B;
        8: w[27:24] = aabr_pkg::CLS_COPROC_POST;
        default: w[27:24] = aabr_pkg::CLS_COPROC_PRE;
      endcase
      if ($urandom_range(0, 3) == 0) w[11:7] = '0;
    end
    return w;
  endfunction

  task automatic send_random();
    send_instr(random_instr(), random_word(), random_word(), 1'($urandom_range(0, 1)));
  endtask

  task automatic test_halfword();
    send_instr(encode(aabr_pkg::CLS_HALF_POST, 1'b1, 1'b1, 1'b0, 4'd0, 16'h0F0F),
               '1, 32'h1234, 1'b0);
    send_instr(encode(aabr_pkg::CLS_HALF_PRE, 1'b0, 1'b0, 1'b1, 4'd15, 16'h0000),
               '1, '1, 1'b1);
    send_instr(encode(aabr_pkg::CLS_HALF_PRE, 1'b1, 1'b0, 1'b0, 4'd7, 16'h0000),
               32'h100, '1, 1'b0);
  endtask

  task automatic test_immediate();
    send_instr(encode(aabr_pkg::CLS_IMM_POST, 1'b1, 1'b0, 1'b0, 4'd1, 16'h0FFF),
               '0, '0, 1'b0);
    send_instr(encode(aabr_pkg::CLS_IMM_PRE, 1'b0, 1'b1, 1'b1, 4'd2, 16'h0FFF),
               '1, '0, 1'b0);
    send_instr(encode(aabr_pkg::CLS_IMM_PRE, 1'b1, 1'b0, 1'b0, 4'd3, 16'h0004),
               32'h40, '0, 1'b0);
  endtask

  task automatic test_register_shift();
    send_instr(encode(aabr_pkg::CLS_REG_POST, 1'b1, 1'b0, 1'b0, 4'd4,
                      {4'h0, 5'd0, aabr_pkg::SHIFT_LSL, 5'h2}),
               32'h1000, 32'h10, 1'b0);
    send_instr(encode(aabr_pkg::CLS_REG_PRE, 1'b0, 1'b0, 1'b1, 4'd5,
                      {4'h0, 5'd31, aabr_pkg::SHIFT_LSL, 5'h2}),
               32'h1000, '1, 1'b0);
    send_instr(encode(aabr_pkg::CLS_REG_POST, 1'b0, 1'b0, 1'b0, 4'd6,
                      {4'h0, 5'd0, aabr_pkg::SHIFT_LSR, 5'h2}),
               32'h1000, '1, 1'b0);
    send_instr(encode(aabr_pkg::CLS_REG_POST, 1'b1, 1'b0, 1'b0, 4'd6,
                      {4'h0, 5'd1, aabr_pkg::SHIFT_LSR, 5'h2}),
               32'h1000, '1, 1'b0);
    send_instr(encode(aabr_pkg::CLS_REG_POST, 1'b1, 1'b0, 1'b0, 4'd8,
                      {4'h0, 5'd0, aabr_pkg::SHIFT_ASR, 5'h2}),
               32'h1000, 32'h8000_0001, 1'b0);
    send_instr(encode(aabr_pkg::CLS_REG_POST, 1'b0, 1'b0, 1'b0, 4'd8,
                      {4'h0, 5'd31, aabr_pkg::SHIFT_ASR, 5'h2}),
               32'h1000, 32'h8000_0000, 1'b0);
    send_instr(encode(aabr_pkg::CLS_REG_POST, 1'b1, 1'b0, 1'b0, 4'd9,
                      {4'h0, 5'd0, aabr_pkg::SHIFT_ROR, 5'h2}),
               32'h1000, 32'h0000_0003, 1'b1);
    send_instr(encode(aabr_pkg::CLS_REG_PRE, 1'b0, 1'b0, 1'b1, 4'd9,
                      {4'h0, 5'd7, aabr_pkg::SHIFT_ROR, 5'h2}),
               32'h1000, 32'hDEAD_BEEF, 1'b0);
  endtask

  task automatic test_multiple();
    send_instr(encode(aabr_pkg::CLS_MULTI_A, 1'b1, 1'b0, 1'b1, 4'd13, 16'hFFFF),
               32'h40, '0, 1'b0);
    send_instr(encode(aabr_pkg::CLS_MULTI_B, 1'b0, 1'b0, 1'b1, 4'd13, 16'h0000),
               32'h40, '0, 1'b0);
    send_instr(encode(aabr_pkg::CLS_MULTI_A, 1'b1, 1'b0, 1'b0, 4'd10, 16'h8001),
               32'h40, '0, 1'b0);
  endtask

  task automatic test_coprocessor();
    send_instr(encode(aabr_pkg::CLS_COPROC_POST, 1'b1, 1'b0, 1'b0, 4'd11, 16'h00FF),
               '0, '0, 1'b0);
    send_instr(encode(aabr_pkg::CLS_COPROC_PRE, 1'b0, 1'b0, 1'b1, 4'd12, 16'h00FF),
               '1, '0, 1'b0);
  endtask

  task automatic test_other_classes();
    send_instr(encode(aabr_pkg::CLS_DP_IMM, 1'b1, 1'b1, 1'b1, 4'd14, 16'hFFFF),
               32'hCAFE_F00D, '1, 1'b1);
    send_instr(encode(aabr_pkg::CLS_SWI, 1'b0, 1'b0, 1'b0, 4'd0, 16'hFFFF),
               32'hCAFE_F00D, '1, 1'b1);
  endtask

  task automatic test_backpressure();
    sender_idles = 1'b0;
    @(posedge clk);
    hold_token++;
    repeat (40) send_random();
    sender_idles = 1'b1;
    drain_results();
  endtask

  task automatic test_random_mixed(input int unsigned count);
    repeat (count) send_random();
    drain_results();
  endtask

  task automatic test_random_burst(input int unsigned count);
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    repeat (count) send_random();
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    drain_results();
  endtask

  initial begin
    rst         = 1'b1;
    instr_valid = 1'b0;
    instruction = '0;
    base_value  = '0;
    index_value = '0;
    carry_flag  = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_halfword();
    test_immediate();
    test_register_shift();
    test_multiple();
    test_coprocessor();
    test_other_classes();
    drain_results();
    test_backpressure();
    test_random_mixed(900);
    test_random_burst(200);

    drain_results();
    repeat (8) @(posedge clk);
    if (pending_restores.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, pending_restores.size());
    end
    $display("%0d instruction transfers, %0d results checked: all classes, shift types,",
             sent_count, checked_count);
    $display("writeback rules, random idling, bursts and a long result hold-off.");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
